FILE: rtl/dpd_pkg.sv
package dpd_pkg;

  // Frame layout: id byte, two skipped 64-bit words, magic, 16-bit length.
  localparam int MAGIC_BYTES = 16;
  localparam int MAGIC_START = 17;
  localparam int LEN_START   = MAGIC_START + MAGIC_BYTES;
  localparam int HEADER_END  = LEN_START + 2;
  localparam int KEPT_LENGTHS = 9;
  localparam int MIN_FIELDS   = 6;
  localparam int TAG_LEN      = 4;
  localparam int SEEN_CAP     = 16;

  localparam logic [7:0] ID_BYTE   = 8'h1c;
  localparam logic [7:0] SEP_CHAR  = 8'h3b;
  localparam logic [7:0] ESC_CHAR  = 8'h5c;
  localparam logic [7:0] DIGIT_LO  = 8'h30;
  localparam logic [7:0] DIGIT_HI  = 8'h39;
  localparam logic [31:0] ACC_LIMIT = 32'd429496729;
  localparam logic [3:0]  LAST_DIGIT_MAX = 4'd5;

  // Expected text of field 0.
  localparam logic [7:0] TAG_TEXT [TAG_LEN] = '{8'h4d, 8'h43, 8'h50, 8'h45};

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAME_MODE = 2'd0;
  localparam logic [1:0] REG_MAGIC_HIGH = 2'd1;
  localparam logic [1:0] REG_MAGIC_LOW  = 2'd2;

  localparam logic [63:0] MAGIC_HIGH_RESET = 64'd72056498804555518;
  localparam logic [63:0] MAGIC_LOW_RESET  = 64'd18302063728033398392;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  // Number parse error codes (match the status codes they become).
  localparam logic [1:0] NUM_OK       = 2'd0;
  localparam logic [1:0] NUM_INVALID  = 2'd1;
  localparam logic [1:0] NUM_OVERFLOW = 2'd2;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One queued operation: an optional character beat and an optional summary beat.
  typedef struct packed {
    logic        has_char;
    logic [3:0]  char_field;
    logic [7:0]  char_byte;
    logic        has_sum;
    logic [2:0]  status;
    logic [31:0] num_a;
    logic [31:0] num_b;
    logic [31:0] num_c;
    logic [4:0]  seen;
  } op_t;

endpackage

FILE: rtl/discovery_pong_decoder_unit.sv
// Discovery pong decoder.
// Input channel (in_valid/in_ready): one beat per received byte, with
// end_of_message set on the final byte. Output channel (out_valid/out_ready):
// character beats (item_kind 0) for each kept field character, and one
// summary beat (item_kind 1, final_flag 1) per message with status and numbers.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data): frame
// mode and the two halves of the expected magic; write it only while idle.
// Throughput is one byte per cycle while the queue has room. A byte that yields
// a character and closes the message produces two beats from one queue entry:
// the character beat, then the summary beat held in the output stage. An
// accepted byte is decoded into the queue, then moved into the output register.
// Reset clears all message state, sets frame mode and the default magic, and
// empties the queue and output register.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and in_ready drops once both queue entries are taken.
module discovery_pong_decoder_unit import dpd_pkg::*; #(
  parameter int FIELD_BYTES   = 64,
  parameter int MAX_FIELDS    = 16,
  parameter int NAME_BYTES    = 64,
  parameter int VERSION_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic [3:0]  field_number,
  output logic [7:0]  field_char,
  output logic [2:0]  status,
  output logic [31:0] protocol_number,
  output logic [31:0] players_now,
  output logic [31:0] players_max,
  output logic [4:0]  fields_seen,
  output logic        final_flag
);

  logic q_full, q_push, q_pop, q_empty;
  op_t  push_op, head_op;

  dpd_front #(
    .FIELD_BYTES(FIELD_BYTES), .MAX_FIELDS(MAX_FIELDS),
    .NAME_BYTES(NAME_BYTES), .VERSION_BYTES(VERSION_BYTES)
  ) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
    .data_byte, .end_of_message, .q_full, .q_push, .q_op(push_op)
  );

  dpd_queue u_queue (
    .clk, .rst, .push(q_push), .push_op, .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(head_op)
  );

  dpd_back u_back (
    .clk, .rst, .q_empty, .q_head(head_op), .q_pop, .out_valid, .out_ready,
    .item_kind, .field_number, .field_char, .status, .protocol_number,
    .players_now, .players_max, .fields_seen, .final_flag
  );

`ifndef SYNTHESIS
  a_char_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_CHAR |-> !final_flag && status == ST_OK)
    else $error("character beat carries summary content");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_SUMMARY && status != ST_OK |->
      protocol_number == '0 && players_now == '0 && players_max == '0)
    else $error("failed summary carries numbers");
  a_seen_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_SUMMARY |-> fields_seen <= 5'd16 && final_flag)
    else $error("summary beat malformed");
`endif

endmodule

FILE: rtl/dpd_front.sv
module dpd_front import dpd_pkg::*; #(
  parameter int FIELD_BYTES   = 64,
  parameter int MAX_FIELDS    = 16,
  parameter int NAME_BYTES    = 64,
  parameter int VERSION_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_message,
  input  logic        q_full,
  output logic        q_push,
  output op_t         q_op
);

  localparam int FW = $clog2(FIELD_BYTES);
  localparam int XW = $clog2(MAX_FIELDS + 1);

  logic          frame_mode;
  logic [127:0]  magic;
  logic          esc, esc_next;
  logic [XW-1:0] fi, fi_next;
  logic [FW-1:0] chars, chars_next;
  logic [FW-1:0] closed [KEPT_LENGTHS];
  logic [FW-1:0] closed_next [KEPT_LENGTHS];
  logic          hm, hm_next;
  logic [31:0]   acc [3];
  logic [31:0]   acc_next [3];
  logic [1:0]    err [3];
  logic [1:0]    err_next [3];
  logic [5:0]    cnt, cnt_next;
  logic          mis, mis_next;
  logic          inv, inv_next;
  logic [15:0]   left, left_next;
  op_t           op;
  logic          accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (op.has_char || op.has_sum);
  assign q_op     = op;

  // Per-byte decode: header checks, text split, number parse and end-of-message summary.
  always_comb begin
    logic       do_text;
    logic       store;
    logic       close;
    logic [3:0] mk;
    logic [1:0] slot;
    logic       slot_ok;
    logic [3:0] dig;
    logic       bad;
    esc_next = esc; fi_next = fi; chars_next = chars; closed_next = closed;
    hm_next = hm; acc_next = acc; err_next = err; cnt_next = cnt;
    mis_next = mis; inv_next = inv; left_next = left;
    op = '0; do_text = 1'b0; store = 1'b0; close = 1'b0;
    mk = 4'(32'(cnt) - MAGIC_START);
    slot = 2'd0; slot_ok = 1'b0; dig = data_byte[3:0]; bad = 1'b0;

    // Frame header walk.
    if (frame_mode) begin
      if (!inv) begin
        if (32'(cnt) < HEADER_END) begin
          if (cnt == '0) begin
            if (data_byte != ID_BYTE) inv_next = 1'b1;
          end else if (32'(cnt) >= MAGIC_START && 32'(cnt) < LEN_START) begin
            if (data_byte != magic[(4'd15 - mk) * 8 +: 8]) mis_next = 1'b1;
            if (32'(cnt) == LEN_START - 1 && mis_next) inv_next = 1'b1;
          end else if (32'(cnt) == LEN_START) begin
            left_next = {data_byte, 8'h00};
          end else if (32'(cnt) == LEN_START + 1) begin
            left_next = {left[15:8], data_byte};
            if (left_next == '0) inv_next = 1'b1;
          end
          cnt_next = cnt + 6'd1;
        end else if (left == '0) begin
          inv_next = 1'b1;
        end else begin
          left_next = left - 16'd1;
          do_text = 1'b1;
        end
      end
    end else begin
      do_text = 1'b1;
    end

    // Escape and separator handling.
    if (do_text) begin
      if (esc) begin
        esc_next = 1'b0;
        store = 1'b1;
      end else if (data_byte == ESC_CHAR) begin
        esc_next = 1'b1;
      end else if (data_byte == SEP_CHAR) begin
        close = 1'b1;
      end else begin
        store = 1'b1;
      end
    end

    // Store one character into the open field.
    if (store && 32'(fi) < MAX_FIELDS && 32'(chars) + 1 < FIELD_BYTES) begin
      if (fi == '0 && 32'(chars) < TAG_LEN && data_byte != TAG_TEXT[2'(chars)])
        hm_next = 1'b0;
      if (fi == XW'(2)) begin
        slot = 2'd0; slot_ok = 1'b1;
      end else if (fi == XW'(4)) begin
        slot = 2'd1; slot_ok = 1'b1;
      end else if (fi == XW'(5)) begin
        slot = 2'd2; slot_ok = 1'b1;
      end
      if (slot_ok && err[slot] == NUM_OK) begin
        if (data_byte < DIGIT_LO || data_byte > DIGIT_HI) begin
          err_next[slot] = NUM_INVALID;
        end else if (acc[slot] > ACC_LIMIT ||
                     (acc[slot] == ACC_LIMIT && dig > LAST_DIGIT_MAX)) begin
          err_next[slot] = NUM_OVERFLOW;
        end else begin
          acc_next[slot] = (acc[slot] << 3) + (acc[slot] << 1) + 32'(dig);
        end
      end
      op.has_char   = 1'b1;
      op.char_field = 4'(fi);
      op.char_byte  = data_byte;
      chars_next    = chars + FW'(1);
    end

    // Close the open field.
    if (close) begin
      if (32'(fi) < MAX_FIELDS) begin
        if (32'(fi) < KEPT_LENGTHS) closed_next[4'(fi)] = chars;
        fi_next = fi + XW'(1);
      end
      chars_next = '0;
    end

    // End of message: judge and summarize, then clear.
    if (end_of_message) begin
      op.has_sum = 1'b1;
      if (frame_mode && inv_next) begin
        op.status = ST_INVALID;
      end else if (frame_mode && (32'(cnt_next) < HEADER_END || left_next != '0)) begin
        op.status = ST_TRUNCATED;
      end else if (esc_next) begin
        op.status = ST_INVALID;
      end else begin
        if (32'(fi_next) < MAX_FIELDS) begin
          if (32'(fi_next) < KEPT_LENGTHS) closed_next[4'(fi_next)] = chars_next;
          fi_next = fi_next + XW'(1);
        end
        for (int i = 1; i <= 5; i++) if (closed_next[i] == '0) bad = 1'b1;
        if (32'(fi_next) < MIN_FIELDS || 32'(closed_next[0]) != TAG_LEN || !hm_next || bad)
          op.status = ST_INVALID;
        else if (err_next[0] != NUM_OK) op.status = {1'b0, err_next[0]};
        else if (err_next[1] != NUM_OK) op.status = {1'b0, err_next[1]};
        else if (err_next[2] != NUM_OK) op.status = {1'b0, err_next[2]};
        else if (32'(closed_next[1]) >= NAME_BYTES ||
                 32'(closed_next[3]) >= VERSION_BYTES)
          op.status = ST_TOO_LONG;
        else op.status = ST_OK;
      end
      op.seen = (32'(fi_next) > SEEN_CAP) ? 5'(SEEN_CAP) : 5'(fi_next);
      if (op.status == ST_OK) begin
        op.num_a = acc_next[0];
        op.num_b = acc_next[1];
        op.num_c = acc_next[2];
      end
      esc_next = 1'b0; fi_next = '0; chars_next = '0; hm_next = 1'b1;
      cnt_next = '0; mis_next = 1'b0; inv_next = 1'b0; left_next = '0;
      for (int i = 0; i < KEPT_LENGTHS; i++) closed_next[i] = '0;
      for (int i = 0; i < 3; i++) begin
        acc_next[i] = '0;
        err_next[i] = NUM_OK;
      end
    end
  end

  // Configuration and message state.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode <= 1'b1;
      magic <= {MAGIC_HIGH_RESET, MAGIC_LOW_RESET};
      esc <= 1'b0; fi <= '0; chars <= '0; hm <= 1'b1;
      cnt <= '0; mis <= 1'b0; inv <= 1'b0; left <= '0;
      for (int i = 0; i < KEPT_LENGTHS; i++) closed[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        acc[i] <= '0;
        err[i] <= NUM_OK;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_MODE: frame_mode <= cfg_data[0];
          REG_MAGIC_HIGH: magic[127:64] <= cfg_data;
          REG_MAGIC_LOW:  magic[63:0] <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        esc <= esc_next; fi <= fi_next; chars <= chars_next; closed <= closed_next;
        hm <= hm_next; acc <= acc_next; err <= err_next; cnt <= cnt_next;
        mis <= mis_next; inv <= inv_next; left <= left_next;
      end
    end
  end

endmodule

FILE: rtl/dpd_queue.sv
module dpd_queue import dpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic empty,
  output op_t  head
);

  op_t        mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = mem[rptr];

  // Two-entry ring of operations between decode and output.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        mem[wptr] <= push_op;
        wptr <= !wptr;
      end
      if (pop) rptr <= !rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/dpd_back.sv
module dpd_back import dpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  op_t         q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic [3:0]  field_number,
  output logic [7:0]  field_char,
  output logic [2:0]  status,
  output logic [31:0] protocol_number,
  output logic [31:0] players_now,
  output logic [31:0] players_max,
  output logic [4:0]  fields_seen,
  output logic        final_flag
);

  logic sum_pend;
  op_t  held;
  logic slot_free;

  assign slot_free = !out_valid || out_ready;
  assign q_pop     = slot_free && !sum_pend && !q_empty;

  // Output register: a character beat, then a held summary beat if one follows, or a summary beat alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sum_pend  <= 1'b0;
    end else if (slot_free) begin
      out_valid <= 1'b0;
      if (sum_pend) begin
        sum_pend <= 1'b0;
        out_valid <= 1'b1;
        item_kind <= KIND_SUMMARY;
        field_number <= '0; field_char <= '0;
        status <= held.status; protocol_number <= held.num_a;
        players_now <= held.num_b; players_max <= held.num_c;
        fields_seen <= held.seen; final_flag <= 1'b1;
      end else if (!q_empty) begin
        if (q_head.has_char) begin
          out_valid <= 1'b1;
          item_kind <= KIND_CHAR;
          field_number <= q_head.char_field; field_char <= q_head.char_byte;
          status <= ST_OK; protocol_number <= '0; players_now <= '0;
          players_max <= '0; fields_seen <= '0; final_flag <= 1'b0;
          sum_pend <= q_head.has_sum;
          held <= q_head;
        end else if (q_head.has_sum) begin
          out_valid <= 1'b1;
          item_kind <= KIND_SUMMARY;
          field_number <= '0; field_char <= '0;
          status <= q_head.status; protocol_number <= q_head.num_a;
          players_now <= q_head.num_b; players_max <= q_head.num_c;
          fields_seen <= q_head.seen; final_flag <= 1'b1;
        end
      end
    end
  end

endmodule
